[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the trust table.
// Depends on nothing; assertions vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define ASSERT_IMPL(label, prop, msg)
`define ASSERT_NEVER(label, prop, msg)
`endif
`endif

[rtl/udptt_pkg.sv]
// Package for the UDP trust table: sizes, protocol constants and state codes.
// Depends on nothing.
package udptt_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam logic [15:0] EthIpv4 = 16'h0800;
  localparam logic [7:0] ProtoUdp = 8'h11;
  localparam logic [31:0] AgeLimitReset = 32'd1000;
  localparam logic ReqFrame = 1'b0;
  localparam logic ReqTick = 1'b1;

  typedef enum logic [3:0] {
    StIdle, StScanRd, StScanChk, StIns, StDelRd, StDelChk, StShiftRd, StShiftWr, StDone
  } state_e;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] tstamp;
    logic        doomed;
  } entry_t;
endpackage

[rtl/udp_trust_table_with_aging_top.sv]
// Trust table of remote IPv4 address and local UDP port pairs, with ageing.
// An item reads each entry scanned and, when a marked entry is removed, moves
// each later entry down by one, through the single read and single write port
// of the entry memory. A result waits in an output register; the next request
// is taken once it has been delivered.
`include "assert_macros.svh"
module udp_trust_table_with_aging_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // eth_type[15:0], ip_protocol[23:16], dst_ip[55:24], src_port[71:56],
  // current_time[103:72]
  input  logic [103:0] s_axis_tdata,
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // was_found, was_inserted, insert_dropped, entry_marked, entry_removed,
  // entry_total[11:5]
  output logic [15:0] m_axis_tdata
);
  localparam int unsigned IdxW = udptt_pkg::IdxW;
  localparam int unsigned CntW = udptt_pkg::CntW;

  udptt_pkg::entry_t mem_q [udptt_pkg::TableDepth];
  udptt_pkg::entry_t rd_q;
  logic [IdxW-1:0] raddr, waddr;
  logic re, we;
  udptt_pkg::entry_t wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rd_q <= mem_q[raddr];
  end

  udptt_pkg::state_e st_q, st_d;
  logic [31:0] age_q, age_d;
  logic [CntW-1:0] cnt_q, cnt_d, i_q, i_d;
  logic kind_q, kind_d, udp_q, udp_d;
  logic [31:0] ip_q, ip_d, now_q, now_d;
  logic [15:0] port_q, port_d;
  logic fnd_q, fnd_d, ins_q, ins_d, drp_q, drp_d, mrk_q, mrk_d, rem_q, rem_d;
  logic ov_q, ov_d;

  assign s_axis_tready = (st_q == udptt_pkg::StIdle) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = {4'd0, cnt_q, rem_q, mrk_q, drp_q, ins_q, fnd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= udptt_pkg::StIdle;
      age_q <= udptt_pkg::AgeLimitReset;
      cnt_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      age_q <= age_d;
      cnt_q <= cnt_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; kind_q <= kind_d; udp_q <= udp_d; ip_q <= ip_d; now_q <= now_d;
    port_q <= port_d; fnd_q <= fnd_d; ins_q <= ins_d; drp_q <= drp_d;
    mrk_q <= mrk_d; rem_q <= rem_d;
  end

  always_comb begin
    st_d = st_q; age_d = cfg_we_i ? cfg_wdata_i : age_q; cnt_d = cnt_q;
    ov_d = ov_q && !m_axis_tready; i_d = i_q; kind_d = kind_q; udp_d = udp_q;
    ip_d = ip_q; now_d = now_q; port_d = port_q; fnd_d = fnd_q; ins_d = ins_q;
    drp_d = drp_q; mrk_d = mrk_q; rem_d = rem_q;
    re = 1'b0; we = 1'b0; raddr = i_q[IdxW-1:0]; waddr = i_q[IdxW-1:0]; wdata = rd_q;
    case (st_q)
      udptt_pkg::StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          kind_d = s_axis_tuser;
          udp_d = (s_axis_tdata[15:0] == udptt_pkg::EthIpv4) &&
                  (s_axis_tdata[23:16] == udptt_pkg::ProtoUdp);
          ip_d = s_axis_tdata[55:24]; port_d = s_axis_tdata[71:56];
          now_d = s_axis_tdata[103:72];
          fnd_d = 1'b0; ins_d = 1'b0; drp_d = 1'b0; mrk_d = 1'b0; rem_d = 1'b0;
          i_d = '0;
          if (s_axis_tuser == udptt_pkg::ReqFrame && !udp_d) st_d = udptt_pkg::StDelRd;
          else st_d = udptt_pkg::StScanRd;
        end
      end
      udptt_pkg::StScanRd: begin
        if (i_q >= cnt_q) begin
          if (kind_q == udptt_pkg::ReqTick) st_d = udptt_pkg::StDone;
          else st_d = udptt_pkg::StIns;
        end else begin
          re = 1'b1; st_d = udptt_pkg::StScanChk;
        end
      end
      udptt_pkg::StScanChk: begin
        st_d = udptt_pkg::StScanRd;
        i_d = i_q + 1'b1;
        if (kind_q == udptt_pkg::ReqTick) begin
          if ((now_q - rd_q.tstamp) > age_q) begin
            we = 1'b1; wdata.doomed = 1'b1; mrk_d = 1'b1; st_d = udptt_pkg::StDone;
          end
        end else if (rd_q.ip == ip_q && rd_q.port == port_q) begin
          we = 1'b1; wdata.tstamp = now_q; fnd_d = 1'b1;
          i_d = '0; st_d = udptt_pkg::StDelRd;
        end
      end
      udptt_pkg::StIns: begin
        i_d = '0; st_d = udptt_pkg::StDelRd;
        if (cnt_q < CntW'(udptt_pkg::TableDepth)) begin
          we = 1'b1; waddr = cnt_q[IdxW-1:0];
          wdata = '{ip: ip_q, port: port_q, tstamp: now_q, doomed: 1'b0};
          cnt_d = cnt_q + 1'b1; ins_d = 1'b1;
        end else drp_d = 1'b1;
      end
      udptt_pkg::StDelRd: begin
        if (i_q >= cnt_q) st_d = udptt_pkg::StDone;
        else begin re = 1'b1; st_d = udptt_pkg::StDelChk; end
      end
      udptt_pkg::StDelChk: begin
        if (rd_q.doomed) begin
          rem_d = 1'b1; st_d = udptt_pkg::StShiftRd;
        end else begin
          i_d = i_q + 1'b1; st_d = udptt_pkg::StDelRd;
        end
      end
      udptt_pkg::StShiftRd: begin
        if (i_q + 1'b1 >= cnt_q) begin
          cnt_d = cnt_q - 1'b1; st_d = udptt_pkg::StDone;
        end else begin
          re = 1'b1; raddr = IdxW'(i_q + 1'b1); st_d = udptt_pkg::StShiftWr;
        end
      end
      udptt_pkg::StShiftWr: begin
        we = 1'b1; i_d = i_q + 1'b1; st_d = udptt_pkg::StShiftRd;
      end
      udptt_pkg::StDone: begin
        ov_d = 1'b1; st_d = udptt_pkg::StIdle;
      end
      default: st_d = udptt_pkg::StIdle;
    endcase
  end

  `ASSERT_NEVER(a_cnt_range, cnt_q > CntW'(udptt_pkg::TableDepth), "count exceeds depth")
  `ASSERT_NEVER(a_one_outcome, ov_q && ($countones({fnd_q, ins_q, drp_q}) > 1), "outcomes clash")
  `ASSERT_NEVER(a_tick_flags, ov_q && kind_q && (fnd_q || ins_q || rem_q), "tick frame flags")
  `ASSERT_IMPL(a_done_out, st_q == udptt_pkg::StDone |=> m_axis_tvalid, "result lost")
endmodule

[tb/udp_trust_table_with_aging_checker.sv]
// Checker for the UDP trust table: watches both streams, keeps its own copy of
// the table and compares every result with the predicted one. Uses udptt_pkg.
`timescale 1ns / 1ps
module udp_trust_table_with_aging_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [15:0]  m_axis_tdata,
  output int           fail_count_o,
  output int           pending_o
);
  typedef struct packed {
    logic       found;
    logic       inserted;
    logic       dropped;
    logic       marked;
    logic       removed;
    logic [6:0] total;
  } verdict_t;

  logic [31:0] tbl_ip [udptt_pkg::TableDepth];
  logic [15:0] tbl_port [udptt_pkg::TableDepth];
  logic [31:0] tbl_time [udptt_pkg::TableDepth];
  logic        tbl_doomed [udptt_pkg::TableDepth];
  int unsigned tbl_used;
  logic [31:0] age_limit;
  verdict_t    verdicts_due [$];

  assign pending_o = verdicts_due.size();

  function automatic verdict_t table_step(logic kind, logic [103:0] d);
    verdict_t v;
    logic [15:0] et;
    logic [7:0] pr;
    logic [31:0] ip, now;
    logic [15:0] port;
    et = d[15:0];
    pr = d[23:16];
    ip = d[55:24];
    port = d[71:56];
    now = d[103:72];
    v = '0;
    if (kind == udptt_pkg::ReqTick) begin
      for (int i = 0; i < tbl_used; i++) begin
        if (32'(now - tbl_time[i]) > age_limit) begin
          tbl_doomed[i] = 1'b1;
          v.marked = 1'b1;
          break;
        end
      end
    end else begin
      if (et == udptt_pkg::EthIpv4 && pr == udptt_pkg::ProtoUdp) begin
        for (int i = 0; i < tbl_used; i++) begin
          if (tbl_ip[i] == ip && tbl_port[i] == port) begin
            tbl_time[i] = now;
            v.found = 1'b1;
            break;
          end
        end
        if (!v.found) begin
          if (tbl_used < udptt_pkg::TableDepth) begin
            tbl_ip[tbl_used] = ip;
            tbl_port[tbl_used] = port;
            tbl_time[tbl_used] = now;
            tbl_doomed[tbl_used] = 1'b0;
            tbl_used++;
            v.inserted = 1'b1;
          end else begin
            v.dropped = 1'b1;
          end
        end
      end
      for (int i = 0; i < tbl_used; i++) begin
        if (tbl_doomed[i]) begin
          for (int j = i; j + 1 < tbl_used; j++) begin
            tbl_ip[j] = tbl_ip[j + 1];
            tbl_port[j] = tbl_port[j + 1];
            tbl_time[j] = tbl_time[j + 1];
            tbl_doomed[j] = tbl_doomed[j + 1];
          end
          tbl_used--;
          v.removed = 1'b1;
          break;
        end
      end
    end
    v.total = 7'(tbl_used);
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want, got;
    if (!rst_ni) begin
      tbl_used = 0;
      age_limit = udptt_pkg::AgeLimitReset;
      verdicts_due.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) age_limit = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        verdicts_due.push_back(table_step(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = '0;
        got.found = m_axis_tdata[0];
        got.inserted = m_axis_tdata[1];
        got.dropped = m_axis_tdata[2];
        got.marked = m_axis_tdata[3];
        got.removed = m_axis_tdata[4];
        got.total = m_axis_tdata[11:5];
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          fail_count_o++;
        end else begin
          want = verdicts_due.pop_front();
          if (want.found != got.found || want.inserted != got.inserted ||
              want.dropped != got.dropped || want.marked != got.marked ||
              want.removed != got.removed || want.total != got.total) begin
            $display("%0t: mismatch, expected %b%b%b%b%b n%0d, actual %b%b%b%b%b n%0d",
                     $time, want.found, want.inserted, want.dropped, want.marked,
                     want.removed, want.total, got.found, got.inserted, got.dropped,
                     got.marked, got.removed, got.total);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule

[tb/udp_trust_table_with_aging_top_test.sv]
// Top of the trust table testbench: drives requests, ticks and age limits
// into the block and gives the verdict. Depends on the checker and udptt_pkg.
`timescale 1ns / 1ps
module udp_trust_table_with_aging_top_test;
  localparam int Latency = 300;
  localparam int Limit = 20000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [31:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;
  int           fail_count, pending;
  int           idle_cycles = 0;
  logic [31:0]  clock_now = '0;
  logic [31:0]  peer_ip [8];
  logic [15:0]  peer_port [8];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  udp_trust_table_with_aging_top dut (.*);
  udp_trust_table_with_aging_checker checker_i (.*, .fail_count_o(fail_count),
                                                .pending_o(pending));

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready || m_axis_tvalid && m_axis_tready) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > Limit) begin
      $display("udp_trust_table_with_aging_top_test failed");
      $finish;
    end
  end

  initial begin
    int wait_n;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready || !m_axis_tready) begin
        wait_n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
        if (wait_n > 0) begin
          m_axis_tready <= 1'b0;
          repeat (wait_n) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(logic kind, logic [15:0] et, logic [7:0] pr, logic [31:0] ip,
                              logic [15:0] port, logic [31:0] now);
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {now, port, ip, pr, et};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic udp_frame(logic [31:0] ip, logic [15:0] port, logic [31:0] now);
    send_request(udptt_pkg::ReqFrame, udptt_pkg::EthIpv4, udptt_pkg::ProtoUdp, ip, port, now);
  endtask

  task automatic drain_and_set_limit(logic [31:0] lim);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int pick;
    logic [31:0] lims [5];
    lims = '{32'd0, 32'hFFFF_FFFF, 32'd50, 32'd1000, 32'd300};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 8; i++) begin
      peer_ip[i] = $urandom;
      peer_port[i] = 16'($urandom);
    end
    udp_frame(32'h0, 16'h0, 32'h0);
    udp_frame(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    udp_frame(32'h0, 16'h0, 32'd10);
    send_request(udptt_pkg::ReqFrame, 16'h86DD, udptt_pkg::ProtoUdp, 32'h1, 16'h1, 32'd20);
    send_request(udptt_pkg::ReqFrame, udptt_pkg::EthIpv4, 8'h06, 32'h1, 16'h1, 32'd20);
    send_request(udptt_pkg::ReqTick, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd500);
    send_request(udptt_pkg::ReqTick, 16'h0, 8'h0, 32'h0, 16'h0, 32'd2000);
    send_request(udptt_pkg::ReqTick, 16'h0, 8'h0, 32'h0, 16'h0, 32'd2000);
    udp_frame(32'hFFFF_FFFF, 16'hFFFF, 32'd2001);
    send_request(udptt_pkg::ReqFrame, 16'h0, 8'h0, 32'h0, 16'h0, 32'd2002);
    drain_and_set_limit(32'd0);
    for (int i = 0; i < 66; i++) udp_frame(32'(i), 16'(i * 3), 32'd2100);
    send_request(udptt_pkg::ReqTick, 16'h0, 8'h0, 32'h0, 16'h0, 32'd2101);
    udp_frame(32'd5, 16'd15, 32'd2102);
    for (int i = 0; i < 10; i++) udp_frame(32'(i), 16'(i * 3), 32'd2103);
    for (int phase = 1; phase < 5; phase++) begin
      drain_and_set_limit(lims[phase]);
      for (int n = 0; n < 290; n++) begin
        clock_now += $urandom_range(0, 40);
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          udp_frame(peer_ip[$urandom_range(0, 7)] ^ $urandom_range(0, 7),
                    peer_port[$urandom_range(0, 7)], clock_now);
        end else if (pick < 8) begin
          send_request(udptt_pkg::ReqTick, 16'($urandom), 8'($urandom), $urandom,
                       16'($urandom),
                       ($urandom_range(0, 9) == 0) ? $urandom : clock_now);
        end else begin
          send_request(udptt_pkg::ReqFrame,
                       ($urandom_range(0, 1) ? udptt_pkg::EthIpv4 : 16'($urandom)),
                       ($urandom_range(0, 1) ? udptt_pkg::ProtoUdp : 8'($urandom)),
                       $urandom, 16'($urandom), $urandom);
        end
      end
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("udp_trust_table_with_aging_top_test passed");
    end else begin
      $display("udp_trust_table_with_aging_top_test failed");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/udptt_pkg.sv
rtl/udp_trust_table_with_aging_top.sv
tb/udp_trust_table_with_aging_checker.sv
tb/udp_trust_table_with_aging_top_test.sv
